// File: sv/swgc_pkg.sv
// ----------------------------------------------------------------------------
// Sliding-window GC content: shared package
// Field widths, character codes, queue entry type and the IUPAC weight table.
// ----------------------------------------------------------------------------
package swgc_pkg;

   localparam int BYTE_W   = 8;
   localparam int WS_W     = 13;
   localparam int IDX_W    = 32;
   localparam int WEIGHT_W = 14;
   localparam int FRAC_W   = 16;
   localparam int WS_RESET = 100;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [BYTE_W-1:0] CH_HEADER  = 8'h3E;  // '>'
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;  // '\n'
   localparam logic [BYTE_W-1:0] CH_N       = 8'h4E;  // 'N'
   localparam logic [BYTE_W-1:0] CH_S       = 8'h53;  // 'S'
   localparam logic [BYTE_W-1:0] CH_W       = 8'h57;  // 'W'

   // One request handed from the front end to the window engine.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              clear;
      logic              symbol;
   } entry_type;

   typedef struct packed {
      logic [1:0] gc;
      logic [1:0] at;
   } weight_type;

   function automatic weight_type symbol_weights(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] u;
      weight_type        w;
      u = b;
      if (b >= "a" && b <= "z") begin
         u = b - 8'h20;
      end
      unique case (u)
         "C", "G":           w = '{gc: 2'd1, at: 2'd0};
         "A", "T":           w = '{gc: 2'd0, at: 2'd1};
         CH_S:               w = '{gc: 2'd2, at: 2'd0};
         CH_W:               w = '{gc: 2'd0, at: 2'd2};
         "M", "R", "Y", "K": w = '{gc: 2'd1, at: 2'd1};
         "V", "B":           w = '{gc: 2'd2, at: 2'd1};
         "H", "D":           w = '{gc: 2'd1, at: 2'd2};
         CH_N:               w = '{gc: 2'd2, at: 2'd2};
         default:            w = '{gc: 2'd0, at: 2'd0};
      endcase
      return w;
   endfunction

endpackage

// File: sv/swgc_if.sv
// ----------------------------------------------------------------------------
// Sliding-window GC content: channel interfaces
// Valid/ready channels for the byte requests and the window results.
// ----------------------------------------------------------------------------
interface swgc_req_if;
   logic                          valid;
   logic                          ready;
   logic [swgc_pkg::BYTE_W-1:0]   data_byte;
   logic                          new_file;

   modport source (output valid, output data_byte, output new_file, input ready);
   modport sink   (input valid, input data_byte, input new_file, output ready);
endinterface

interface swgc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [swgc_pkg::IDX_W-1:0]      window_index;
   logic [swgc_pkg::WEIGHT_W-1:0]   gc_weight;
   logic [swgc_pkg::WEIGHT_W-1:0]   at_weight;
   logic [swgc_pkg::FRAC_W-1:0]     gc_fraction;
   logic                            fraction_valid;

   modport source (output valid, output window_index, output gc_weight, output at_weight,
                   output gc_fraction, output fraction_valid, input ready);
   modport sink   (input valid, input window_index, input gc_weight, input at_weight,
                   input gc_fraction, input fraction_valid, output ready);
endinterface

// File: sv/swgc_ram.sv
// ----------------------------------------------------------------------------
// Sliding-window GC content: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swgc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/swgc_fifo.sv
// ----------------------------------------------------------------------------
// Sliding-window GC content: request queue
// Short FIFO that decouples the byte classifier from the window engine.
// ----------------------------------------------------------------------------
module swgc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  swgc_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output swgc_pkg::entry_type pop_data,
   output logic                empty
);

   localparam int PTR_W = $clog2(swgc_pkg::QUEUE_DEPTH);

   swgc_pkg::entry_type entry_ff [swgc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]      count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(swgc_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/swgc_front.sv
// ----------------------------------------------------------------------------
// Sliding-window GC content: front end
// Tracks FASTA header and line-start state and queues sequence symbols.
// ----------------------------------------------------------------------------
module swgc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                stream_clear,
   swgc_req_if.sink            req,
   output logic                push,
   output swgc_pkg::entry_type push_data,
   input  logic                full
);

   logic header_mode_ff, header_mode_in;
   logic line_start_ff, line_start_in;
   logic accept;
   logic hm_eff, ls_eff;
   logic is_symbol;

   assign req.ready = !full;
   assign accept    = req.valid && !full;

   always_comb begin
      // A new file clears the parser state before the byte is looked at.
      hm_eff         = req.new_file ? 1'b0 : header_mode_ff;
      ls_eff         = req.new_file ? 1'b1 : line_start_ff;
      header_mode_in = header_mode_ff;
      line_start_in  = line_start_ff;
      is_symbol      = 1'b0;
      priority if (req.data_byte == swgc_pkg::CH_NEWLINE) begin
         header_mode_in = 1'b0;
         line_start_in  = 1'b1;
      end else if (ls_eff && req.data_byte == swgc_pkg::CH_HEADER) begin
         header_mode_in = 1'b1;
         line_start_in  = 1'b0;
      end else begin
         header_mode_in = hm_eff;
         line_start_in  = ls_eff;
         is_symbol      = !hm_eff;
      end
      if (!accept) begin
         header_mode_in = header_mode_ff;
         line_start_in  = line_start_ff;
      end
   end

   assign push                = accept && (is_symbol || req.new_file);
   assign push_data.data_byte = req.data_byte;
   assign push_data.clear     = req.new_file;
   assign push_data.symbol    = is_symbol;

   always_ff @(posedge clock) begin
      if (reset || stream_clear) begin
         header_mode_ff <= 1'b0;
         line_start_ff  <= 1'b1;
      end else begin
         header_mode_ff <= header_mode_in;
         line_start_ff  <= line_start_in;
      end
   end

endmodule

// File: sv/swgc_back.sv
// ----------------------------------------------------------------------------
// Sliding-window GC content: window engine
// Symbol ring, running weight sums, serial divider and the result register.
// ----------------------------------------------------------------------------
module swgc_back #(
   parameter int MAX_WINDOW = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [swgc_pkg::WS_W-1:0]     csr_wdata,
   input  logic                          empty,
   input  swgc_pkg::entry_type           pop_data,
   output logic                          pop,
   swgc_rsp_if.source                    rsp
);

   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = $clog2(2 * MAX_WINDOW + 1);
   localparam int DEN_W  = SUM_W + 1;
   localparam int REM_W  = SUM_W + 2;
   localparam int STEP_W = $clog2(swgc_pkg::FRAC_W);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } back_state_type;

   back_state_type                   state_ff, state_in;
   logic [swgc_pkg::WS_W-1:0]        window_size_ff, window_size_in;
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [SUM_W-1:0]                 strong_ff, strong_in;
   logic [SUM_W-1:0]                 weak_ff, weak_in;
   logic [swgc_pkg::IDX_W-1:0]       counter_ff, counter_in;
   logic [swgc_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic [REM_W-1:0]                 rem_ff, rem_in;
   logic [DEN_W-1:0]                 den_ff, den_in;
   logic [swgc_pkg::FRAC_W-1:0]      quot_ff, quot_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic                             fval_ff, fval_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [swgc_pkg::IDX_W-1:0]       out_idx_ff, out_idx_in;
   logic [swgc_pkg::WEIGHT_W-1:0]    out_gc_ff, out_gc_in;
   logic [swgc_pkg::WEIGHT_W-1:0]    out_at_ff, out_at_in;
   logic [swgc_pkg::FRAC_W-1:0]      out_frac_ff, out_frac_in;
   logic                             out_fval_ff, out_fval_in;

   logic [31:0]                      ws_wide;
   logic [FILL_W-1:0]                size_eff;
   logic                             full;
   swgc_pkg::weight_type             old_w, new_w;
   logic [SUM_W-1:0]                 strong_next, weak_next;
   logic [FILL_W-1:0]                fill_next;
   logic [DEN_W-1:0]                 den_next;
   logic                             ram_rd_en, ram_wr_en;
   logic [SLOT_W-1:0]                ram_rd_addr;
   logic [swgc_pkg::BYTE_W-1:0]      ram_rd_data;
   logic                             div_ge;
   logic [REM_W-1:0]                 div_diff;

   swgc_ram #(
      .WIDTH (swgc_pkg::BYTE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (byte_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Window size clamped to the range the ring supports.
   always_comb begin
      ws_wide = 32'(window_size_ff);
      if (ws_wide < 32'd2) begin
         size_eff = FILL_W'(2);
      end else if (ws_wide > 32'(MAX_WINDOW)) begin
         size_eff = FILL_W'(MAX_WINDOW);
      end else begin
         size_eff = FILL_W'(ws_wide);
      end
   end

   assign full        = (fill_ff >= size_eff);
   assign old_w       = swgc_pkg::symbol_weights(ram_rd_data);
   assign new_w       = swgc_pkg::symbol_weights(byte_ff);
   assign strong_next = strong_ff - (full ? SUM_W'(old_w.gc) : '0) + SUM_W'(new_w.gc);
   assign weak_next   = weak_ff - (full ? SUM_W'(old_w.at) : '0) + SUM_W'(new_w.at);
   assign fill_next   = full ? fill_ff : fill_ff + 1'b1;
   assign den_next    = DEN_W'(strong_next) + DEN_W'(weak_next);

   assign pop         = (state_ff == S_IDLE) && !empty;
   assign ram_rd_en   = pop && pop_data.symbol;
   assign ram_rd_addr = pop_data.clear ? '0 : slot_ff;
   assign ram_wr_en   = (state_ff == S_READ);

   // One restoring division step: compare, subtract, shift.
   assign div_ge   = (rem_ff >= REM_W'(den_ff));
   assign div_diff = div_ge ? rem_ff - REM_W'(den_ff) : rem_ff;

   always_comb begin
      state_in       = state_ff;
      window_size_in = window_size_ff;
      slot_in        = slot_ff;
      fill_in        = fill_ff;
      strong_in      = strong_ff;
      weak_in        = weak_ff;
      counter_in     = counter_ff;
      byte_in        = byte_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      quot_in        = quot_ff;
      step_in        = step_ff;
      fval_in        = fval_ff;
      out_idx_in     = out_idx_ff;
      out_gc_in      = out_gc_ff;
      out_at_in      = out_at_ff;
      out_frac_in    = out_frac_ff;
      out_fval_in    = out_fval_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               if (pop_data.clear) begin
                  slot_in    = '0;
                  fill_in    = '0;
                  strong_in  = '0;
                  weak_in    = '0;
                  counter_in = '0;
               end
               if (pop_data.symbol) begin
                  byte_in  = pop_data.data_byte;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            strong_in = strong_next;
            weak_in   = weak_next;
            fill_in   = fill_next;
            slot_in   = (FILL_W'(slot_ff) + 1'b1 == size_eff) ? '0 : slot_ff + 1'b1;
            if (fill_next >= size_eff) begin
               if (den_next == '0) begin
                  quot_in  = '0;
                  fval_in  = 1'b0;
                  state_in = S_DONE;
               end else begin
                  rem_in   = REM_W'(strong_next);
                  den_in   = den_next;
                  quot_in  = '0;
                  step_in  = '0;
                  fval_in  = 1'b1;
                  state_in = S_DIV;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            rem_in  = {div_diff[REM_W-2:0], 1'b0};
            quot_in = {quot_ff[swgc_pkg::FRAC_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(swgc_pkg::FRAC_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_idx_in   = counter_ff;
               out_gc_in    = swgc_pkg::WEIGHT_W'(strong_ff);
               out_at_in    = swgc_pkg::WEIGHT_W'(weak_ff);
               out_frac_in  = quot_ff;
               out_fval_in  = fval_ff;
               rsp_valid_in = 1'b1;
               counter_in   = counter_ff + 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write restarts the stream under the new window size.
      if (csr_we) begin
         window_size_in = csr_wdata;
         slot_in        = '0;
         fill_in        = '0;
         strong_in      = '0;
         weak_in        = '0;
         counter_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_size_ff <= swgc_pkg::WS_W'(swgc_pkg::WS_RESET);
         slot_ff        <= '0;
         fill_ff        <= '0;
         strong_ff      <= '0;
         weak_ff        <= '0;
         counter_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         slot_ff        <= slot_in;
         fill_ff        <= fill_in;
         strong_ff      <= strong_in;
         weak_ff        <= weak_in;
         counter_ff     <= counter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      fval_ff     <= fval_in;
      out_idx_ff  <= out_idx_in;
      out_gc_ff   <= out_gc_in;
      out_at_ff   <= out_at_in;
      out_frac_ff <= out_frac_in;
      out_fval_ff <= out_fval_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.window_index   = out_idx_ff;
   assign rsp.gc_weight      = out_gc_ff;
   assign rsp.at_weight      = out_at_ff;
   assign rsp.gc_fraction    = out_frac_ff;
   assign rsp.fraction_valid = out_fval_ff;

endmodule

// File: sv/sliding_window_gc_content_top.sv
// ----------------------------------------------------------------------------
// Sliding-window GC content: top level
// FASTA byte classifier, request queue and sliding-window weight engine.
// ----------------------------------------------------------------------------
// Each request carries one FASTA byte. Newlines and header lines are consumed
// by the front end, which holds every byte while the queue is full; sequence
// symbols go through a four-entry queue to the window engine, which reads the
// evicted symbol from the ring RAM in S_IDLE and updates the running sums in
// S_READ. A symbol that leaves the window full then goes through the bit-serial
// Q1.15 divider, skipped when both sums are zero, and S_DONE loads the result
// register; the engine pops no new symbol until that is done. Writing csr_wdata
// restarts the stream with the new window size, clamped to 2..MAX_WINDOW.
module sliding_window_gc_content_top #(
   parameter int MAX_WINDOW = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [swgc_pkg::WS_W-1:0]  csr_wdata,
   swgc_req_if.sink                   req_bus,
   swgc_rsp_if.source                 rsp_bus
);

   logic                push;
   swgc_pkg::entry_type push_data;
   logic                full;
   logic                pop;
   swgc_pkg::entry_type pop_data;
   logic                empty;

   swgc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .stream_clear (csr_we),
      .req          (req_bus),
      .push         (push),
      .push_data    (push_data),
      .full         (full)
   );

   swgc_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   swgc_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule
